### design/psxadpcm_pkg.sv
// Shared types, constants and coefficient tables for the SPU ADPCM block decoder.
// No dependencies; used by the front, queue, back end and top level.
package psxadpcm_pkg;

    localparam int SAMPLES_PER_BLOCK = 28;
    localparam int SAMPLE_IDX_W      = $clog2(SAMPLES_PER_BLOCK);
    localparam int DATA_LOW_W        = 64;
    localparam int DATA_HIGH_W       = 48;
    localparam int DATA_W            = DATA_LOW_W + DATA_HIGH_W;
    localparam int NIBBLE_W          = 4;
    localparam int SAMPLE_W          = 16;
    localparam int COEF_W            = 8;
    localparam int PROD_W            = SAMPLE_W + COEF_W;
    localparam int PRED_SHIFT        = 6;
    localparam int NIBBLE_POS        = 12;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [3:0] SHIFT_MAX  = 4'd12;
    localparam logic [3:0] FILTER_MAX = 4'd3;

    localparam logic signed [SAMPLE_W-1:0] PCM_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] PCM_MIN = -16'sh8000;

    localparam logic [SAMPLE_IDX_W-1:0] LAST_IDX = SAMPLE_IDX_W'(SAMPLES_PER_BLOCK - 1);

    // One block that is to be decoded, as classified by the front end.
    typedef struct packed {
        logic              first;
        logic              ends;
        logic              mute;
        logic [1:0]        filter;
        logic [3:0]        shift;
        logic [DATA_W-1:0] data;
    } blk_entry_t;

    // Predictor weight applied to the previous sample.
    function automatic logic signed [COEF_W-1:0] coef_a(input logic [1:0] filt);
        logic signed [COEF_W-1:0] c;
        unique case (filt)
            2'd0: c = 8'sd0;
            2'd1: c = 8'sd60;
            2'd2: c = 8'sd115;
            2'd3: c = 8'sd98;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // Predictor weight applied to the sample before the previous one.
    function automatic logic signed [COEF_W-1:0] coef_b(input logic [1:0] filt);
        logic signed [COEF_W-1:0] c;
        unique case (filt)
            2'd0: c = 8'sd0;
            2'd1: c = 8'sd0;
            2'd2: c = -8'sd52;
            2'd3: c = -8'sd55;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

### design/psxadpcm_front.sv
// Front end: accepts blocks, tracks the stopped state and classifies each block.
// Depends on psxadpcm_pkg.
module psxadpcm_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_first_block,
    input  logic                                s_final_block,
    input  logic [3:0]                          s_shift_amount,
    input  logic [3:0]                          s_filter_select,
    input  logic                                s_end_flag,
    input  logic [psxadpcm_pkg::DATA_LOW_W-1:0] s_data_low,
    input  logic [psxadpcm_pkg::DATA_HIGH_W-1:0] s_data_high,
    input  logic                                q_full,
    output logic                                q_push,
    output psxadpcm_pkg::blk_entry_t            q_entry
);

    logic stopped_reg;
    logic stopped_next;
    logic eff_stopped;
    logic accept;
    logic ends;

    assign s_ready     = !q_full;
    assign accept      = s_valid && s_ready;
    assign ends        = s_end_flag || s_final_block;
    // A first block restarts the sound even after a stop.
    assign eff_stopped = s_first_block ? 1'b0 : stopped_reg;
    assign q_push      = accept && !eff_stopped;
    assign stopped_next = eff_stopped || ends;

    always_comb begin
        q_entry.first  = s_first_block;
        q_entry.ends   = ends;
        q_entry.mute   = s_shift_amount > psxadpcm_pkg::SHIFT_MAX;
        q_entry.filter = (s_filter_select > psxadpcm_pkg::FILTER_MAX)
                         ? psxadpcm_pkg::FILTER_MAX[1:0] : s_filter_select[1:0];
        q_entry.shift  = s_shift_amount;
        q_entry.data   = {s_data_high, s_data_low};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg <= 1'b0;
        end else if (accept) begin
            stopped_reg <= stopped_next;
        end
    end

endmodule

### design/psxadpcm_queue.sv
// Short first-in first-out queue of classified blocks between front and back end.
// Depends on psxadpcm_pkg for the entry type.
module psxadpcm_queue #(
    parameter int DEPTH = psxadpcm_pkg::QUEUE_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     push,
    input  psxadpcm_pkg::blk_entry_t push_entry,
    output logic                     full,
    input  logic                     pop,
    output logic                     empty,
    output psxadpcm_pkg::blk_entry_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    psxadpcm_pkg::blk_entry_t entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign empty      = count_reg == '0;
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_entry = entries[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### design/psxadpcm_back.sv
// Back end: decodes a queued block into 28 registered samples, one per cycle unless stalled.
// Depends on psxadpcm_pkg for the entry type, constants and predictor coefficients.
module psxadpcm_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  q_empty,
    input  psxadpcm_pkg::blk_entry_t              q_entry,
    output logic                                  q_pop,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [psxadpcm_pkg::SAMPLE_W-1:0] m_pcm_sample,
    output logic                                  m_block_last,
    output logic                                  m_sound_end
);

    localparam int SW    = psxadpcm_pkg::SAMPLE_W;
    localparam int PW    = psxadpcm_pkg::PROD_W;
    localparam int SUM_W = PW + 2;

    logic                                   busy_reg;
    logic [psxadpcm_pkg::SAMPLE_IDX_W-1:0]  idx_reg;
    logic [psxadpcm_pkg::DATA_W-1:0]        data_reg;
    logic                                   ends_reg;
    logic                                   mute_reg;
    logic [1:0]                             filter_reg;
    logic [3:0]                             shift_reg;
    logic signed [SW-1:0]                   h1_reg;
    logic signed [SW-1:0]                   h2_reg;
    logic                                   out_valid_reg;
    logic signed [SW-1:0]                   pcm_reg;
    logic                                   last_reg;
    logic                                   end_reg;

    logic                                   step;
    logic                                   at_last;
    logic                                   load;
    logic signed [SW-1:0]                   nib_pos;
    logic signed [SW-1:0]                   scaled;
    logic signed [PW-1:0]                   prod_a;
    logic signed [PW-1:0]                   prod_b;
    logic signed [PW:0]                     pred_sum;
    logic signed [SUM_W-1:0]                total;
    logic signed [SW-1:0]                   sample;

    assign step    = busy_reg && (!out_valid_reg || m_ready);
    assign at_last = idx_reg == psxadpcm_pkg::LAST_IDX;
    assign load    = !q_empty && (!busy_reg || (step && at_last));
    assign q_pop   = load;

    assign m_valid      = out_valid_reg;
    assign m_pcm_sample = pcm_reg;
    assign m_block_last = last_reg;
    assign m_sound_end  = end_reg;

    // One sample: scaled nibble plus filtered history, saturated; zero for a muted block.
    always_comb begin
        nib_pos  = {data_reg[psxadpcm_pkg::NIBBLE_W-1:0], {psxadpcm_pkg::NIBBLE_POS{1'b0}}};
        scaled   = nib_pos >>> shift_reg;
        prod_a   = PW'(h1_reg) * PW'(psxadpcm_pkg::coef_a(filter_reg));
        prod_b   = PW'(h2_reg) * PW'(psxadpcm_pkg::coef_b(filter_reg));
        pred_sum = (PW + 1)'(prod_a) + (PW + 1)'(prod_b);
        total    = SUM_W'(scaled) + SUM_W'(pred_sum >>> psxadpcm_pkg::PRED_SHIFT);
        if (mute_reg) begin
            sample = '0;
        end else if (total > SUM_W'(psxadpcm_pkg::PCM_MAX)) begin
            sample = psxadpcm_pkg::PCM_MAX;
        end else if (total < SUM_W'(psxadpcm_pkg::PCM_MIN)) begin
            sample = psxadpcm_pkg::PCM_MIN;
        end else begin
            sample = total[SW-1:0];
        end
    end

    // Payload registers: block parameters, data shifter, history and output sample.
    always_ff @(posedge aclk) begin
        if (step) begin
            data_reg <= data_reg >> psxadpcm_pkg::NIBBLE_W;
            h2_reg   <= h1_reg;
            h1_reg   <= sample;
            pcm_reg  <= sample;
            last_reg <= at_last;
            end_reg  <= at_last && ends_reg;
        end
        if (load) begin
            data_reg   <= q_entry.data;
            ends_reg   <= q_entry.ends;
            mute_reg   <= q_entry.mute;
            filter_reg <= q_entry.filter;
            shift_reg  <= q_entry.shift;
            if (q_entry.first) begin
                h1_reg <= '0;
                h2_reg <= '0;
            end
        end
        if (!aresetn) begin
            h1_reg <= '0;
            h2_reg <= '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                out_valid_reg <= 1'b1;
                idx_reg       <= idx_reg + 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (load) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (step && at_last) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sound_end |-> m_block_last)
        else $error("sound end flagged on a sample that does not close its block");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && mute_reg |=> pcm_reg == '0)
        else $error("muted block produced a nonzero sample");

    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !busy_reg || (step && at_last))
        else $error("new block loaded while the current one is unfinished");

    assert property (@(posedge aclk) disable iff (!aresetn)
        step && at_last && !load |=> !busy_reg)
        else $error("decoder still busy after the last sample of a block");

endmodule

### design/psx_adpcm_block_decoder_core.sv
// Top level of the SPU ADPCM block decoder: front end, block queue and back end.
// Depends on psxadpcm_pkg, psxadpcm_front, psxadpcm_queue and psxadpcm_back.
//
// Usage: each input item on the s_ channel is one 16-byte SPU ADPCM block, split
// into its header nibbles, the end flag, the 14 data bytes and two stream markers
// (first_block, final_block). Each decoded block yields 28 result items on the
// m_ channel, one signed 16-bit sample each, low nibble of each byte first.
// m_block_last marks the 28th sample; m_sound_end marks the last sample of a sound.
// After a sound ends, further blocks are accepted and dropped without any result
// until a block with first_block set restarts the sound with cleared history.
// When the back end is idle, a block goes through the queue and the back end's
// block and output registers before its first sample appears. The back end gives
// one sample per cycle while the receiver takes them, set by the history feedback
// through predictor and saturation datapath. The queue holds QUEUE_DEPTH classified
// blocks, so the front accepts blocks while the back end decodes or the
// receiver stalls. While a sample waits and m_ready is low, the output register
// holds it and decoding pauses. Reset (aresetn low, synchronous) empties the
// queue, clears the history and stopped state, and drops any sample in flight.
module psx_adpcm_block_decoder_core #(
    parameter int QUEUE_DEPTH = psxadpcm_pkg::QUEUE_DEPTH
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic                                     s_first_block,
    input  logic                                     s_final_block,
    input  logic [3:0]                               s_shift_amount,
    input  logic [3:0]                               s_filter_select,
    input  logic                                     s_end_flag,
    input  logic [psxadpcm_pkg::DATA_LOW_W-1:0]      s_data_low,
    input  logic [psxadpcm_pkg::DATA_HIGH_W-1:0]     s_data_high,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [psxadpcm_pkg::SAMPLE_W-1:0] m_pcm_sample,
    output logic                                     m_block_last,
    output logic                                     m_sound_end
);

    // Classified blocks travel from the front end to the queue and on to the back end.
    psxadpcm_pkg::blk_entry_t push_entry;
    psxadpcm_pkg::blk_entry_t head_entry;
    logic                     q_push;
    logic                     q_full;
    logic                     q_pop;
    logic                     q_empty;

    // The front end drops blocks that arrive after a sound has ended.
    psxadpcm_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_block   (s_first_block),
        .s_final_block   (s_final_block),
        .s_shift_amount  (s_shift_amount),
        .s_filter_select (s_filter_select),
        .s_end_flag      (s_end_flag),
        .s_data_low      (s_data_low),
        .s_data_high     (s_data_high),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_entry         (push_entry)
    );

    psxadpcm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_entry (head_entry)
    );

    // The back end owns the sample history and the output register.
    psxadpcm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_entry      (head_entry),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pcm_sample (m_pcm_sample),
        .m_block_last (m_block_last),
        .m_sound_end  (m_sound_end)
    );

endmodule

### dv/psx_adpcm_block_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for psx_adpcm_block_decoder_core: SPU ADPCM blocks in, PCM samples out.
// Depends on psxadpcm_pkg and the decoder RTL; needs no files or arguments at run time.
module psx_adpcm_block_decoder_core_tb;

    // The run has no absolute length. It ends on its own once the last expected
    // sample has arrived, or when the watchdog sees no item accepted for too long.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;
    localparam int SETTLE_CYCLES  = 32;
    localparam int PHASE_BLOCKS   = 115;
    localparam int REPORT_LIMIT   = 10;

    // The filter select nibble picks one of four predictor weight pairs.
    // Any value above the last pair behaves as the last pair.
    localparam logic [3:0] FILTER_NONE       = 4'd0;
    localparam logic [3:0] FILTER_ONE_POLE   = 4'd1;
    localparam logic [3:0] FILTER_TWO_POLE   = 4'd2;
    localparam logic [3:0] FILTER_TWO_POLE_B = 4'd3;

    // Data patterns that push every nibble to one extreme.
    localparam logic [psxadpcm_pkg::DATA_LOW_W-1:0]  LOW_SEVENS  = {16{4'h7}};
    localparam logic [psxadpcm_pkg::DATA_LOW_W-1:0]  LOW_EIGHTS  = {16{4'h8}};
    localparam logic [psxadpcm_pkg::DATA_HIGH_W-1:0] HIGH_SEVENS = {12{4'h7}};
    localparam logic [psxadpcm_pkg::DATA_HIGH_W-1:0] HIGH_EIGHTS = {12{4'h8}};

    // One block as offered on the input channel.
    typedef struct {
        logic                                 first_blk;
        logic                                 final_blk;
        logic [3:0]                           shift;
        logic [3:0]                           filter;
        logic                                 end_flag;
        logic [psxadpcm_pkg::DATA_LOW_W-1:0]  data_low;
        logic [psxadpcm_pkg::DATA_HIGH_W-1:0] data_high;
    } adpcm_block_t;

    // One decoded sample as seen on the result channel.
    typedef struct {
        logic signed [psxadpcm_pkg::SAMPLE_W-1:0] pcm;
        logic                                     blk_last;
        logic                                     snd_end;
    } pcm_sample_t;

    // The scoreboard keeps its own copy of the decoder history and stop state.
    // decode_block() runs each accepted block through that state and queues the
    // 28 samples of each block that is not dropped; check_sample() pops the oldest one and compares.
    class sample_scoreboard;
        int          hist_prev;
        int          hist_older;
        bit          halted;
        pcm_sample_t expected_pcm[$];
        int          blocks_decoded;
        int          blocks_dropped;
        int          samples_checked;
        int          mismatches;

        function void decode_block(adpcm_block_t blk);
            logic [psxadpcm_pkg::DATA_W-1:0] bytes;
            logic signed [3:0] code;
            logic [3:0]        filt;
            int                wa;
            int                wb;
            int                acc;
            int                k;
            bit                sound_over;
            pcm_sample_t       smp;
            sound_over = blk.end_flag || blk.final_blk;
            if (blk.first_blk) begin
                hist_prev = 0;
                hist_older = 0;
                halted = 1'b0;
            end
            if (halted) begin
                blocks_dropped++;
                return;
            end
            filt = (blk.filter > psxadpcm_pkg::FILTER_MAX) ? psxadpcm_pkg::FILTER_MAX
                                                           : blk.filter;
            case (filt)
                FILTER_NONE: begin
                    wa = 0;
                    wb = 0;
                end
                FILTER_ONE_POLE: begin
                    wa = 60;
                    wb = 0;
                end
                FILTER_TWO_POLE: begin
                    wa = 115;
                    wb = -52;
                end
                default: begin
                    wa = 98;
                    wb = -55;
                end
            endcase
            // Sample k takes nibble k of the 14 data bytes, low nibble first.
            bytes = {blk.data_high, blk.data_low};
            for (k = 0; k < psxadpcm_pkg::SAMPLES_PER_BLOCK; k++) begin
                code = bytes[4*k +: 4];
                if (blk.shift > psxadpcm_pkg::SHIFT_MAX) begin
                    acc = 0;
                end else begin
                    acc = ((int'(code) <<< psxadpcm_pkg::NIBBLE_POS) >>> blk.shift)
                        + ((hist_prev * wa + hist_older * wb) >>> psxadpcm_pkg::PRED_SHIFT);
                    if (acc > int'(psxadpcm_pkg::PCM_MAX)) acc = int'(psxadpcm_pkg::PCM_MAX);
                    if (acc < int'(psxadpcm_pkg::PCM_MIN)) acc = int'(psxadpcm_pkg::PCM_MIN);
                end
                hist_older = hist_prev;
                hist_prev = acc;
                smp.pcm = acc[psxadpcm_pkg::SAMPLE_W-1:0];
                smp.blk_last = (k == psxadpcm_pkg::SAMPLES_PER_BLOCK - 1);
                smp.snd_end = smp.blk_last && sound_over;
                expected_pcm.push_back(smp);
            end
            if (sound_over) halted = 1'b1;
            blocks_decoded++;
        endfunction

        function void check_sample(logic signed [psxadpcm_pkg::SAMPLE_W-1:0] pcm,
                                   logic blk_last, logic snd_end);
            pcm_sample_t want;
            if (expected_pcm.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected sample: pcm=%0d last=%0b end=%0b",
                             pcm, blk_last, snd_end);
                return;
            end
            want = expected_pcm.pop_front();
            samples_checked++;
            if (want.pcm !== pcm || want.blk_last !== blk_last || want.snd_end !== snd_end)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"sample %0d: expected pcm=%0d last=%0b end=%0b, ",
                              "got pcm=%0d last=%0b end=%0b"},
                             samples_checked, want.pcm, want.blk_last, want.snd_end,
                             pcm, blk_last, snd_end);
            end
        endfunction
    endclass

    logic                                     aclk;
    logic                                     aresetn         = 1'b0;
    logic                                     s_valid         = 1'b0;
    logic                                     s_ready;
    logic                                     s_first_block   = 1'b0;
    logic                                     s_final_block   = 1'b0;
    logic [3:0]                               s_shift_amount  = 4'd0;
    logic [3:0]                               s_filter_select = 4'd0;
    logic                                     s_end_flag      = 1'b0;
    logic [psxadpcm_pkg::DATA_LOW_W-1:0]      s_data_low      = '0;
    logic [psxadpcm_pkg::DATA_HIGH_W-1:0]     s_data_high     = '0;
    logic                                     m_valid;
    logic                                     m_ready         = 1'b0;
    logic signed [psxadpcm_pkg::SAMPLE_W-1:0] m_pcm_sample;
    logic                                     m_block_last;
    logic                                     m_sound_end;

    // Percent of cycles in which each side idles; changed between phases.
    int source_idle_pct = 0;
    int sink_idle_pct   = 0;
    // Set by the stimulus to make the receiver refuse samples for a long stretch.
    bit hold_request    = 1'b0;

    sample_scoreboard scoreboard;

    psx_adpcm_block_decoder_core i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_first_block   (s_first_block),
        .s_final_block   (s_final_block),
        .s_shift_amount  (s_shift_amount),
        .s_filter_select (s_filter_select),
        .s_end_flag      (s_end_flag),
        .s_data_low      (s_data_low),
        .s_data_high     (s_data_high),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pcm_sample    (m_pcm_sample),
        .m_block_last    (m_block_last),
        .m_sound_end     (m_sound_end)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic logic [psxadpcm_pkg::DATA_LOW_W-1:0] random_low();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [psxadpcm_pkg::DATA_HIGH_W-1:0] random_high();
        return {16'($urandom), $urandom};
    endfunction

    function automatic adpcm_block_t block_of(logic first_blk, logic final_blk, logic end_flag,
                                              logic [3:0] shift, logic [3:0] filter,
                                              logic [psxadpcm_pkg::DATA_LOW_W-1:0] lo,
                                              logic [psxadpcm_pkg::DATA_HIGH_W-1:0] hi);
        adpcm_block_t blk;
        blk.first_blk = first_blk;
        blk.final_blk = final_blk;
        blk.end_flag  = end_flag;
        blk.shift     = shift;
        blk.filter    = filter;
        blk.data_low  = lo;
        blk.data_high = hi;
        return blk;
    endfunction

    // A block in the middle of a sound. Muting shifts are kept rare so that
    // the history carries real values most of the time, and the end flag and the
    // final marker are each set in about one block in ten.
    function automatic adpcm_block_t random_block();
        adpcm_block_t blk;
        blk.first_blk = 1'b0;
        blk.final_blk = ($urandom_range(9) == 0);
        blk.end_flag  = ($urandom_range(9) == 0);
        blk.shift     = ($urandom_range(7) == 0) ? 4'($urandom_range(15, 13))
                                                 : 4'($urandom_range(12, 0));
        blk.filter    = $urandom_range(1) ? 4'($urandom_range(3)) : 4'($urandom_range(15));
        case ($urandom_range(7))
            0: begin
                blk.data_low  = LOW_SEVENS;
                blk.data_high = HIGH_SEVENS;
            end
            1: begin
                blk.data_low  = LOW_EIGHTS;
                blk.data_high = HIGH_EIGHTS;
            end
            2: begin
                blk.data_low  = '1;
                blk.data_high = '1;
            end
            default: begin
                blk.data_low  = random_low();
                blk.data_high = random_high();
            end
        endcase
        return blk;
    endfunction

    // Offers one block and returns once it has been accepted. A random gap may
    // come first; valid stays high between back-to-back items so that it is
    // never dropped and raised again in one time step.
    task automatic send_block(input adpcm_block_t blk);
        if (source_idle_pct > 0 && $urandom_range(99) < source_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < source_idle_pct);
        end
        s_valid         <= 1'b1;
        s_first_block   <= blk.first_blk;
        s_final_block   <= blk.final_blk;
        s_shift_amount  <= blk.shift;
        s_filter_select <= blk.filter;
        s_end_flag      <= blk.end_flag;
        s_data_low      <= blk.data_low;
        s_data_high     <= blk.data_high;
        do @(posedge aclk); while (!s_ready);
        scoreboard.decode_block(blk);
    endtask

    // The sender goes quiet until every expected sample has come out, then
    // waits a little longer so that a stray extra sample would still be seen.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (scoreboard.expected_pcm.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Plays whole sounds until the given number of blocks has been offered.
    // Each sound starts with a first block and usually ends with the end flag,
    // the final marker or both. Now and then a sound is left open, so the next
    // first block restarts the history in the middle of a sound. Stray blocks
    // after a sound exercise the stopped state.
    task automatic play_random_sounds(input int goal);
        adpcm_block_t blk;
        int           sent;
        int           extra;
        int           noise;
        int           k;
        sent = 0;
        while (sent < goal) begin
            extra = $urandom_range(7);
            for (k = 0; k <= extra; k++) begin
                blk = random_block();
                blk.first_blk = (k == 0);
                if (k == extra && $urandom_range(9) != 0) begin
                    case ($urandom_range(2))
                        0: blk.end_flag = 1'b1;
                        1: blk.final_blk = 1'b1;
                        default: begin
                            blk.end_flag = 1'b1;
                            blk.final_blk = 1'b1;
                        end
                    endcase
                end
                send_block(blk);
                sent++;
            end
            noise = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            for (k = 0; k < noise; k++) begin
                send_block(random_block());
                sent++;
            end
        end
    endtask

    // Receiver: checks each accepted sample and drives ready for the next cycle.
    // A hold request from the stimulus keeps ready low until a countdown from LONG_HOLD,
    // kept here, runs out, while the sender keeps offering blocks.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                scoreboard.check_sample(m_pcm_sample, m_block_last, m_sound_end);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no item moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("psx_adpcm_block_decoder_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int phase;
        scoreboard = new();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed blocks: nibble and shift extremes, each filter, the clamped
        // filter values, both saturation limits, muted blocks, blocks dropped
        // while stopped, a first block that also ends the sound, a restart in
        // the middle of a sound and a final block.
        send_block(block_of(1, 0, 0, 4'd0, FILTER_NONE, LOW_SEVENS, HIGH_SEVENS));
        send_block(block_of(0, 0, 0, 4'd0, FILTER_NONE, LOW_EIGHTS, HIGH_EIGHTS));
        send_block(block_of(0, 0, 0, 4'd4, FILTER_ONE_POLE, random_low(), random_high()));
        send_block(block_of(0, 0, 0, 4'd0, FILTER_TWO_POLE, LOW_SEVENS, HIGH_SEVENS));
        send_block(block_of(0, 0, 0, 4'd0, FILTER_TWO_POLE_B, LOW_EIGHTS, HIGH_EIGHTS));
        // Largest live shift with the largest filter nibble and all nibbles at -1.
        send_block(block_of(0, 0, 0, psxadpcm_pkg::SHIFT_MAX, 4'hF, '1, '1));
        // The smallest muting shift; the block after it starts from zero history.
        send_block(block_of(0, 0, 0, 4'd13, FILTER_TWO_POLE, random_low(), random_high()));
        send_block(block_of(0, 0, 0, 4'd5, FILTER_TWO_POLE, random_low(), random_high()));
        send_block(block_of(0, 0, 0, 4'hF, FILTER_ONE_POLE, LOW_SEVENS, HIGH_SEVENS));
        send_block(block_of(0, 0, 0, 4'd2, 4'd4, '0, '0));
        // The end flag stops the sound; the next two blocks must be dropped.
        send_block(block_of(0, 0, 1, 4'd1, FILTER_ONE_POLE, random_low(), random_high()));
        send_block(block_of(0, 0, 0, 4'd0, FILTER_TWO_POLE, random_low(), random_high()));
        send_block(block_of(0, 1, 1, 4'd3, FILTER_ONE_POLE, random_low(), random_high()));
        // A one-block sound: decoded, then stopped again.
        send_block(block_of(1, 0, 1, 4'd0, FILTER_TWO_POLE_B, LOW_SEVENS, HIGH_SEVENS));
        send_block(block_of(0, 0, 0, 4'd7, FILTER_NONE, random_low(), random_high()));
        send_block(block_of(1, 0, 0, 4'd0, FILTER_TWO_POLE_B, LOW_SEVENS, HIGH_SEVENS));
        send_block(block_of(0, 0, 0, 4'd1, FILTER_TWO_POLE, '1, '1));
        // A first block while the sound is still running clears the history.
        send_block(block_of(1, 0, 0, 4'd6, FILTER_TWO_POLE, random_low(), random_high()));
        send_block(block_of(0, 1, 0, 4'd0, FILTER_ONE_POLE, random_low(), random_high()));
        send_block(block_of(0, 0, 1, 4'd9, FILTER_TWO_POLE, random_low(), random_high()));
        // A muted one-block sound with every marker set.
        send_block(block_of(1, 1, 1, 4'd14, FILTER_TWO_POLE_B, random_low(), random_high()));
        send_block(block_of(1, 0, 0, 4'd12, FILTER_ONE_POLE, random_low(), random_high()));
        wait_for_drain();

        // Random sounds in three idle mixes: a slow receiver, a slow sender, and
        // neither idling. The first mix opens with a long receiver hold so the
        // block queue fills and the input stalls. Between mixes the sender waits
        // for every expected sample.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    source_idle_pct = 27;
                    sink_idle_pct   = 57;
                    hold_request    = 1'b1;
                end
                1: begin
                    source_idle_pct = 57;
                    sink_idle_pct   = 27;
                end
                default: begin
                    source_idle_pct = 0;
                    sink_idle_pct   = 0;
                end
            endcase
            play_random_sounds(PHASE_BLOCKS);
            wait_for_drain();
        end

        $display("covered %0d decoded blocks and %0d blocks dropped while stopped, %0d samples",
                 scoreboard.blocks_decoded, scoreboard.blocks_dropped,
                 scoreboard.samples_checked);
        $display("idle mixes: slow receiver with a long hold, slow sender, none; %0d mismatches",
                 scoreboard.mismatches);
        if (scoreboard.mismatches == 0 && scoreboard.expected_pcm.size() == 0) begin
            $display("psx_adpcm_block_decoder_core regression: pass");
        end else begin
            $display("psx_adpcm_block_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
